// ===== design/smavg_pkg.sv =====
package smavg_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_W           = 7;
  localparam int WINDOW_RESET    = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_HOLD
  } smavg_state_t;

endpackage

// ===== design/simple_moving_average.sv =====
// channel | ports                                       | direction
// input   | in_valid, in_ready, in_sample, in_first_... | item in
// result  | out_valid, out_ready, out_average           | item out
// config  | cfg_wr_en, cfg_wr_data                      | window write
//
// an item passes through the read and update states, and an item that yields a
// result (the window is then full) goes on through the bit-serial divide state.
// reset (rst_n, synchronous) clears sum, fill count, write slot and sets window = 8 (at most WINDOW_MAX).
// a finished result sits in the output register while the next item is taken;
// the block stalls only when a second result is ready before the first is taken.
module simple_moving_average import smavg_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_first_of_series,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  input  logic                          cfg_wr_en,
  input  logic        [CFG_W-1:0]       cfg_wr_data
);

  localparam int SLOT_W  = $clog2(WINDOW_MAX);
  localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = SAMPLE_BITS + SLOT_W;
  localparam int CMP_W   = (CFG_W > WIN_W) ? CFG_W : WIN_W;
  localparam int WIN_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  smavg_state_t state_r, state_nxt;

  logic        [WIN_W-1:0]       win_r;
  logic        [WIN_W-1:0]       cfg_win;
  logic        [CMP_W-1:0]       cfg_ext;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic        [SLOT_W-1:0]      slot_r, slot_nxt;
  logic        [WIN_W-1:0]       fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic        [SLOT_W:0]        old_raw;
  logic        [SLOT_W-1:0]      old_addr;
  logic        [SAMPLE_BITS-1:0] old_data;
  logic                          full;
  logic                          produce;
  logic                          accept;
  logic                          rd_en;
  logic                          wr_en;
  logic                          div_start;
  logic                          div_done;
  logic signed [SAMPLE_BITS-1:0] div_q;
  logic                          out_load;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_average_r;

  // clamp written window to 1..WINDOW_MAX
  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    if (cfg_ext == '0) begin
      cfg_win = WIN_W'(1);
    end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
      cfg_win = WIN_W'(WINDOW_MAX);
    end else begin
      cfg_win = WIN_W'(cfg_ext);
    end
  end

  // slot that entered win_r items ago
  always_comb begin
    old_raw = (SLOT_W+1)'(slot_r) + (SLOT_W+1)'(WINDOW_MAX) - (SLOT_W+1)'(win_r);
    if (old_raw >= (SLOT_W+1)'(WINDOW_MAX)) begin
      old_addr = SLOT_W'(old_raw - (SLOT_W+1)'(WINDOW_MAX));
    end else begin
      old_addr = old_raw[SLOT_W-1:0];
    end
  end

  always_comb begin
    full     = (fill_r >= win_r);
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    produce  = (fill_nxt >= win_r);
    slot_nxt = (slot_r == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_r + 1'b1;
    sum_nxt  = sum_r + SUM_W'(sample_r)
             - (full ? SUM_W'($signed(old_data)) : SUM_W'(0));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = produce ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (div_done) state_nxt = out_load ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   rd_en = 1'b1;
      ST_UPDATE: begin
        wr_en     = 1'b1;
        div_start = produce;
      end
      ST_DIV:    out_load = div_done && (!out_valid_r || out_ready);
      ST_HOLD:   out_load = !out_valid_r || out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_W'(WIN_RST);
      sum_r  <= '0;
      fill_r <= '0;
      slot_r <= '0;
    end else if (cfg_wr_en) begin
      win_r  <= cfg_win;
      sum_r  <= '0;
      fill_r <= '0;
      slot_r <= '0;
    end else if (accept && in_first_of_series) begin
      sum_r  <= '0;
      fill_r <= '0;
      slot_r <= '0;
    end else if (wr_en) begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_average_r <= div_q;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  smavg_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (SLOT_W),
    .DW    (SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (rd_en),
    .rd_addr (old_addr),
    .rd_data (old_data)
  );

  smavg_div #(
    .SUM_W (SUM_W),
    .WIN_W (WIN_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (win_r),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ===== design/smavg_ring.sv =====
module smavg_ring import smavg_pkg::*; #(
  parameter int DEPTH = WINDOW_MAX_DEF,
  parameter int AW    = $clog2(WINDOW_MAX_DEF),
  parameter int DW    = SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/smavg_div.sv =====
module smavg_div import smavg_pkg::*; #(
  parameter int SUM_W = SAMPLE_BITS_DEF + $clog2(WINDOW_MAX_DEF),
  parameter int WIN_W = $clog2(WINDOW_MAX_DEF + 1),
  parameter int Q_W   = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic        [WIN_W-1:0] divisor,
  output logic                    done,
  output logic signed [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [WIN_W-1:0] rem_r, rem_nxt;
  logic [WIN_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             neg_r;
  logic             done_r;
  logic [WIN_W:0]   trial;
  logic [WIN_W:0]   diff;
  logic             ge;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] quo_signed;

  assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // one quotient bit per cycle, restoring
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(SUM_W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = quo_signed[Q_W-1:0];
  assign done       = done_r;

endmodule
